>>> rtl/meuf_pkg.sv
// Package with shared codes, field widths and wall masks for the maze union-find block.
package meuf_pkg;

  localparam int unsigned COORD_W  = 6;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned WALL_W   = 4;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;

  // Largest side length; the coordinate and count widths are sized for it.
  localparam int unsigned MAX_SIDE = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'd64;

  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONNECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_JOINED    = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam logic [WALL_W-1:0] WALL_RIGHT  = 4'd1;
  localparam logic [WALL_W-1:0] WALL_BOTTOM = 4'd2;
  localparam logic [WALL_W-1:0] WALL_LEFT   = 4'd4;
  localparam logic [WALL_W-1:0] WALL_TOP    = 4'd8;
  localparam logic [WALL_W-1:0] WALL_ALL    = 4'd15;
  localparam logic [WALL_W-1:0] WALL_FIRST  = 4'd11;
  localparam logic [WALL_W-1:0] WALL_LAST   = 4'd14;

  typedef struct packed {
    logic [WALL_W-1:0] own;
    logic [WALL_W-1:0] nbr;
  } wall_pair_t;

  // Wall bits knocked out on the current cell and on its neighbor.
  function automatic wall_pair_t clear_masks(input logic [1:0] dir);
    wall_pair_t m;
    case (dir)
      DIR_RIGHT: begin m.own = WALL_RIGHT;  m.nbr = WALL_LEFT;   end
      DIR_LEFT:  begin m.own = WALL_LEFT;   m.nbr = WALL_RIGHT;  end
      DIR_DOWN:  begin m.own = WALL_BOTTOM; m.nbr = WALL_TOP;    end
      default:   begin m.own = WALL_TOP;    m.nbr = WALL_BOTTOM; end
    endcase
    return m;
  endfunction

endpackage

>>> rtl/maze_edge_union_find_top.sv
// Top level of the maze union-find block: control sequencer, register file and stores.
// A cell outside the grid goes straight to the result; when only the neighbor is outside,
// the cell's walls are read; else the parent chains of both cells are walked to their
// roots, both cells' walls and ranks are read, and joined sets get the parent, rank and wall updates.
// One item at a time: a request is taken the cycle after the result registers.
// Reset, and every maze_size write, starts a clearing pass over all MAX_SIDE*MAX_SIDE cells
// of all three RAMs, during which no request is accepted.
module maze_edge_union_find_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cell_row[5:0], cell_col[11:6], direction[13:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[1:0], first_walls[5:2], second_walls[9:6],
                                      // sets_left[22:10], complete[23]
);

  localparam int unsigned CELLS  = meuf_pkg::MAX_SIDE * meuf_pkg::MAX_SIDE;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned SW     = meuf_pkg::SIZE_W;
  localparam int unsigned WW     = meuf_pkg::WALL_W;
  localparam int unsigned RW     = meuf_pkg::RANK_W;
  localparam int unsigned CW     = meuf_pkg::COUNT_W;
  localparam logic [SW-1:0] SIDE_MAX = meuf_pkg::SIZE_MAX;
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_F1R   = 5'd2;
  localparam logic [4:0] S_F1C   = 5'd3;
  localparam logic [4:0] S_F2R   = 5'd4;
  localparam logic [4:0] S_F2C   = 5'd5;
  localparam logic [4:0] S_W1R   = 5'd6;
  localparam logic [4:0] S_W1C   = 5'd7;
  localparam logic [4:0] S_W2R   = 5'd8;
  localparam logic [4:0] S_W2C   = 5'd9;
  localparam logic [4:0] S_UPD1  = 5'd10;
  localparam logic [4:0] S_UPD2  = 5'd11;
  localparam logic [4:0] S_DONE  = 5'd12;

  logic [4:0]        state;
  logic [SW-1:0]     maze_size;
  logic [CELL_W-1:0] clr_cnt;
  logic [CW-1:0]     region_count;
  logic [CELL_W-1:0] c1, c2, cur, r1, r2;
  logic [1:0]        dir;
  logic              nbr_ok;
  logic [1:0]        status;
  logic [WW-1:0]     w1, w2;
  logic [RW-1:0]     k1, k2;
  logic              out_valid;
  logic [23:0]       out_data;
  logic              out_load;

  logic [SW-1:0]     cfg_size;
  logic [CELL_W-1:0] last_cell;
  logic [5:0]        in_row, in_col, nbr_row, nbr_col;
  logic [1:0]        in_dir;
  logic              in_cell_ok, in_inside;
  meuf_pkg::wall_pair_t masks;

  logic              wall_we, par_we, rank_we;
  logic [CELL_W-1:0] wall_waddr, par_waddr, rank_waddr;
  logic [CELL_W-1:0] wall_raddr, par_raddr, rank_raddr;
  logic [WW-1:0]     wall_wdata, wall_rdata;
  logic [CELL_W-1:0] par_wdata, par_rdata;
  logic [RW-1:0]     rank_wdata, rank_rdata;
  logic [WW-1:0]     wall_clear;

  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_dir = s_axis_tdata[13:12];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign out_load = (state == S_DONE) && (!out_valid || m_axis_tready);

  always_comb begin
    if (cfg_wdata < meuf_pkg::SIZE_MIN) begin
      cfg_size = meuf_pkg::SIZE_MIN;
    end else if (cfg_wdata > SIDE_MAX) begin
      cfg_size = SIDE_MAX;
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  assign last_cell = CELL_W'((32'(maze_size) - 32'd1) * meuf_pkg::MAX_SIDE +
                             (32'(maze_size) - 32'd1));

  always_comb begin
    in_cell_ok = ({1'b0, in_row} < maze_size) && ({1'b0, in_col} < maze_size);
    nbr_row = in_row;
    nbr_col = in_col;
    case (in_dir)
      meuf_pkg::DIR_RIGHT: begin
        in_inside = ({1'b0, in_col} + 7'd1) < maze_size;
        nbr_col   = in_col + 6'd1;
      end
      meuf_pkg::DIR_LEFT: begin
        in_inside = (in_col != 6'd0);
        nbr_col   = in_col - 6'd1;
      end
      meuf_pkg::DIR_DOWN: begin
        in_inside = ({1'b0, in_row} + 7'd1) < maze_size;
        nbr_row   = in_row + 6'd1;
      end
      default: begin
        in_inside = (in_row != 6'd0);
        nbr_row   = in_row - 6'd1;
      end
    endcase
  end

  assign masks = meuf_pkg::clear_masks(dir);

  always_comb begin
    if (clr_cnt == '0) begin
      wall_clear = meuf_pkg::WALL_FIRST;
    end else if (clr_cnt == last_cell) begin
      wall_clear = meuf_pkg::WALL_LAST;
    end else begin
      wall_clear = meuf_pkg::WALL_ALL;
    end
  end

  // Write ports: the clearing pass owns them, otherwise the update states.
  always_comb begin
    wall_we    = 1'b0;
    wall_waddr = c1;
    wall_wdata = w1 & ~masks.own;
    par_we     = 1'b0;
    par_waddr  = r2;
    par_wdata  = r1;
    rank_we    = 1'b0;
    rank_waddr = r1;
    rank_wdata = k1 + RW'(1);
    case (state)
      S_CLEAR: begin
        wall_we    = 1'b1;
        wall_waddr = clr_cnt;
        wall_wdata = wall_clear;
        par_we     = 1'b1;
        par_waddr  = clr_cnt;
        par_wdata  = clr_cnt;
        rank_we    = 1'b1;
        rank_waddr = clr_cnt;
        rank_wdata = '0;
      end
      S_UPD1: begin
        wall_we = 1'b1;
        par_we  = 1'b1;
        if (k1 < k2) begin
          par_waddr = r1;
          par_wdata = r2;
        end
        rank_we = (k1 == k2);
      end
      S_UPD2: begin
        wall_we    = 1'b1;
        wall_waddr = c2;
        wall_wdata = w2 & ~masks.nbr;
      end
      default: begin
      end
    endcase
  end

  assign par_raddr  = cur;
  assign wall_raddr = (state == S_W2R) ? c2 : c1;
  assign rank_raddr = (state == S_W2R) ? r2 : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_data  <= {region_count == CW'(1), region_count, w2, w1, status};
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      maze_size    <= (meuf_pkg::SIZE_RESET > SIDE_MAX) ? SIDE_MAX : meuf_pkg::SIZE_RESET;
      clr_cnt      <= '0;
      region_count <= '0;
    end else if (cfg_wen) begin
      // A size write restarts the clearing pass from any state.
      maze_size <= cfg_size;
      clr_cnt   <= '0;
      state     <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          region_count <= CW'(maze_size) * CW'(maze_size);
          clr_cnt      <= clr_cnt + CELL_W'(1);
          if (clr_cnt == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dir    <= in_dir;
            nbr_ok <= in_inside;
            c1     <= CELL_W'(32'(in_row) * meuf_pkg::MAX_SIDE + 32'(in_col));
            c2     <= CELL_W'(32'(nbr_row) * meuf_pkg::MAX_SIDE + 32'(nbr_col));
            cur    <= CELL_W'(32'(in_row) * meuf_pkg::MAX_SIDE + 32'(in_col));
            status <= meuf_pkg::ST_OUTSIDE;
            w1     <= '0;
            w2     <= '0;
            if (!in_cell_ok) begin
              state <= S_DONE;
            end else if (!in_inside) begin
              state <= S_W1R;
            end else begin
              state <= S_F1R;
            end
          end
        end
        S_F1R: state <= S_F1C;
        S_F1C: begin
          if (par_rdata == cur) begin
            r1    <= cur;
            cur   <= c2;
            state <= S_F2R;
          end else begin
            cur   <= par_rdata;
            state <= S_F1R;
          end
        end
        S_F2R: state <= S_F2C;
        S_F2C: begin
          if (par_rdata == cur) begin
            r2     <= cur;
            status <= (cur == r1) ? meuf_pkg::ST_CONNECTED : meuf_pkg::ST_JOINED;
            state  <= S_W1R;
          end else begin
            cur   <= par_rdata;
            state <= S_F2R;
          end
        end
        S_W1R: state <= S_W1C;
        S_W1C: begin
          w1    <= wall_rdata;
          k1    <= rank_rdata;
          state <= nbr_ok ? S_W2R : S_DONE;
        end
        S_W2R: state <= S_W2C;
        S_W2C: begin
          w2    <= wall_rdata;
          k2    <= rank_rdata;
          state <= (status == meuf_pkg::ST_JOINED) ? S_UPD1 : S_DONE;
        end
        S_UPD1: begin
          w1 <= wall_wdata;
          if (region_count > CW'(1)) begin
            region_count <= region_count - CW'(1);
          end
          state <= S_UPD2;
        end
        S_UPD2: begin
          w2    <= wall_wdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  meuf_ram #(.WIDTH(WW), .DEPTH(CELLS)) u_wall_ram (
    .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata)
  );

  meuf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  meuf_ram #(.WIDTH(RW), .DEPTH(CELLS)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

endmodule

>>> rtl/meuf_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module meuf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/meuf_checker.sv
// Port-level checker for the maze union-find block, bound to the top level.
module meuf_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wen,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A result held back by the consumer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The completion flag follows the region count.
  a_complete: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[23] == (m_axis_tdata[22:10] == 13'd1)))
    else $error("complete flag does not match sets_left");

  // The region count never drops to zero.
  a_sets_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[22:10] != 13'd0))
    else $error("sets_left is zero");

  // A size write starts the clearing pass, which takes no request.
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> !s_axis_tready)
    else $error("request accepted right after a size write");

endmodule

bind maze_edge_union_find_top meuf_checker u_meuf_checker (
  .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

>>> bench/maze_checker.sv
// Checker for the maze union-find block: predicts each result from the requests and compares.
`timescale 1ns / 100ps
module maze_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count
);
  localparam int SIDE = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int CNT_W = meuf_pkg::COUNT_W;

  typedef struct packed {
    logic [0:0]                    complete;
    logic [meuf_pkg::COUNT_W-1:0]  sets_left;
    logic [meuf_pkg::WALL_W-1:0]   second_walls;
    logic [meuf_pkg::WALL_W-1:0]   first_walls;
    logic [meuf_pkg::STATUS_W-1:0] status;
  } maze_result_t;

  maze_result_t               expected_results[$];
  int                         side_len;
  logic [meuf_pkg::WALL_W-1:0] walls[CELLS];
  int                         parent[CELLS];
  logic [meuf_pkg::RANK_W-1:0] rank[CELLS];
  int                         regions;

  function automatic void clear_maze(input int side);
    side_len = side < 3 ? 3 : (side > SIDE ? SIDE : side);
    for (int i = 0; i < CELLS; i++) begin
      walls[i] = meuf_pkg::WALL_ALL;
      parent[i] = i;
      rank[i] = '0;
    end
    walls[0] = meuf_pkg::WALL_FIRST;
    walls[(side_len - 1) * SIDE + side_len - 1] = meuf_pkg::WALL_LAST;
    regions = side_len * side_len;
  endfunction

  function automatic int root_of(input int c);
    int p;
    for (int s = 0; s < CELLS; s++) begin
      p = parent[c];
      if (p == c) break;
      c = p;
    end
    return c;
  endfunction

  function automatic maze_result_t join_edge(input logic [15:0] req);
    maze_result_t r;
    int row, col, nr, nc, c1, c2, r1, r2;
    bit nbr_ok;
    logic [meuf_pkg::WALL_W-1:0] own_mask, nbr_mask;
    row = int'(req[5:0]);
    col = int'(req[11:6]);
    r = '0;
    if (row < side_len && col < side_len) begin
      nr = row;
      nc = col;
      case (req[13:12])
        meuf_pkg::DIR_RIGHT: begin
          nbr_ok = col + 1 < side_len; nc = col + 1;
          own_mask = meuf_pkg::WALL_RIGHT; nbr_mask = meuf_pkg::WALL_LEFT;
        end
        meuf_pkg::DIR_LEFT: begin
          nbr_ok = col > 0; nc = col - 1;
          own_mask = meuf_pkg::WALL_LEFT; nbr_mask = meuf_pkg::WALL_RIGHT;
        end
        meuf_pkg::DIR_DOWN: begin
          nbr_ok = row + 1 < side_len; nr = row + 1;
          own_mask = meuf_pkg::WALL_BOTTOM; nbr_mask = meuf_pkg::WALL_TOP;
        end
        default: begin
          nbr_ok = row > 0; nr = row - 1;
          own_mask = meuf_pkg::WALL_TOP; nbr_mask = meuf_pkg::WALL_BOTTOM;
        end
      endcase
      c1 = row * SIDE + col;
      if (nbr_ok) begin
        c2 = nr * SIDE + nc;
        r1 = root_of(c1);
        r2 = root_of(c2);
        if (r1 == r2) begin
          r.status = meuf_pkg::ST_CONNECTED;
        end else begin
          r.status = meuf_pkg::ST_JOINED;
          walls[c1] &= ~own_mask;
          walls[c2] &= ~nbr_mask;
          if (rank[r1] < rank[r2]) begin
            parent[r1] = r2;
          end else if (rank[r1] > rank[r2]) begin
            parent[r2] = r1;
          end else begin
            parent[r2] = r1;
            rank[r1] = rank[r1] + 1'b1;
          end
          if (regions > 1) regions--;
        end
        r.second_walls = walls[c2];
      end
      r.first_walls = walls[c1];
    end
    r.sets_left = CNT_W'(regions);
    r.complete = regions == 1;
    return r;
  endfunction

  task automatic compare(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_maze(int'(meuf_pkg::SIZE_RESET));
  end

  always @(posedge clk) begin
    maze_result_t exp_r, act_r;
    if (rst) begin
      clear_maze(int'(meuf_pkg::SIZE_RESET));
    end else begin
      if (cfg_wen) clear_maze(int'(cfg_wdata));
      if (s_axis_tvalid && s_axis_tready) expected_results.push_back(join_edge(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          compare("status", int'(exp_r.status), int'(act_r.status));
          compare("first_walls", int'(exp_r.first_walls), int'(act_r.first_walls));
          compare("second_walls", int'(exp_r.second_walls), int'(act_r.second_walls));
          compare("sets_left", int'(exp_r.sets_left), int'(act_r.sets_left));
          compare("complete", int'(exp_r.complete), int'(act_r.complete));
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

>>> bench/testbench.sv
// Top of the maze union-find bench: clock, reset, stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [6:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          side;
  int          idle_cycles;

  maze_edge_union_find_top DUT (.*);

  maze_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver side: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The request stays offered after acceptance until the next call or a drain drops it;
  // the block is busy after taking a request.
  task automatic send_request(input int row, input int col, input logic [1:0] dir);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, dir, col[5:0], row[5:0]};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_size(input int value);
    drain();
    cfg_wen <= 1;
    cfg_wdata <= 7'(value);
    @(negedge clk);
    cfg_wen <= 0;
    side = value < 3 ? 3 : (value > 64 ? 64 : value);
  endtask

  // Mostly in-grid cells, with some coordinates past the edge.
  task automatic random_requests(input int count);
    int row, col;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        row = $urandom_range(63);
        col = $urandom_range(63);
      end else begin
        row = $urandom_range(side - 1);
        col = $urandom_range(side - 1);
      end
      send_request(row, col, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    rst = 1;
    cfg_wen = 0;
    cfg_wdata = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    m_axis_tready = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    side = 64;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: corners, every direction, edges outside, repeat join, far coordinates.
    send_request(0, 0, meuf_pkg::DIR_RIGHT);
    send_request(0, 0, meuf_pkg::DIR_LEFT);
    send_request(0, 0, meuf_pkg::DIR_UP);
    send_request(0, 0, meuf_pkg::DIR_DOWN);
    send_request(63, 63, meuf_pkg::DIR_DOWN);
    send_request(63, 63, meuf_pkg::DIR_RIGHT);
    send_request(63, 63, meuf_pkg::DIR_UP);
    send_request(63, 63, meuf_pkg::DIR_LEFT);
    send_request(0, 1, meuf_pkg::DIR_LEFT);
    send_request(1, 0, meuf_pkg::DIR_UP);
    send_request(1, 1, meuf_pkg::DIR_UP);
    send_request(1, 1, meuf_pkg::DIR_LEFT);
    write_size(3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_request(r, c, c < 2 ? meuf_pkg::DIR_RIGHT : meuf_pkg::DIR_DOWN);
    send_request(5, 1, meuf_pkg::DIR_RIGHT);
    send_request(42, 21, meuf_pkg::DIR_UP);
    write_size(1);
    send_request(2, 2, meuf_pkg::DIR_LEFT);
    write_size(127);
    send_request(32, 17, meuf_pkg::DIR_DOWN);

    // Small mazes so regions fully merge often, then a larger maze, in each of four stall phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_size($urandom_range(3, 8));
      random_requests(250);
      write_size($urandom_range(9, 64));
      random_requests(140);
    end

    // Long receiver hold-off while requests keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      random_requests(20);
    join
    drain();
    write_size(64);
    random_requests(30);

    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
